/* rtl/spherical_shell_normaliser_core_macros.svh */
// Assertion macros for the spherical shell normaliser checker.
// Clock and reset are taken from the scope that uses them (clk, rst).
`ifndef SPHERICAL_SHELL_NORMALISER_CORE_MACROS_SVH
`define SPHERICAL_SHELL_NORMALISER_CORE_MACROS_SVH

// Checked only outside reset.
`define SSN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SSN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ssn_pkg.sv */
// Shared types and constants of the spherical shell normaliser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ssn_pkg;

  localparam int X_WIDTH     = 20;
  localparam int VALUE_WIDTH = 32;

  // Edges are Q.11, one bit wider than the centres.
  localparam int EDGE_W = X_WIDTH + 1;
  localparam int EXT_W  = X_WIDTH + 3;
  localparam int CUBE_W = 3 * X_WIDTH + 1;
  localparam int DIFF_W = 3 * X_WIDTH + 2;

  // 2 * 3/(4*pi) in Q0.32
  localparam int                KINV_W  = 31;
  localparam logic [KINV_W-1:0] KINV_X2 = 31'd2050695826;
  localparam int                NUM_W   = VALUE_WIDTH + KINV_W;

  // Shared multiplier operand widths
  localparam int SQ_W  = 2 * X_WIDTH + 2;
  localparam int MA_W  = (SQ_W > VALUE_WIDTH + 1) ? SQ_W : VALUE_WIDTH + 1;
  localparam int MB_W  = (EDGE_W > KINV_W + 1) ? EDGE_W : KINV_W + 1;
  localparam int PROD_W = MA_W + MB_W;

  localparam int CNT_W = $clog2(VALUE_WIDTH);

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_ZERO_VOLUME = 2'd1;
  localparam logic [1:0] STATUS_SATURATED   = 2'd2;

  typedef struct packed {
    logic signed [X_WIDTH-1:0]     bin_centre;
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic signed [VALUE_WIDTH-1:0] sample_error;
    logic                          last_bin;
  } ssn_in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] normalised_value;
    logic signed [VALUE_WIDTH-1:0] normalised_error;
    logic [1:0]                    result_status;
    logic                          last_result;
  } ssn_out_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

  typedef struct packed {
    logic                          done;
    logic                          sat;
    logic signed [VALUE_WIDTH-1:0] quot;
  } div_rsp_t;

  typedef enum logic [1:0] {
    BINS_NONE,
    BINS_HELD,
    BINS_STREAM
  } bins_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_STEP,
    DIV_DONE
  } div_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LEFT_SQ,
    ST_LEFT_CUBE,
    ST_LEFT_SET,
    ST_SH_SQ,
    ST_SH_CUBE,
    ST_SH_DIFF,
    ST_SH_CHECK,
    ST_VAL_MUL,
    ST_VAL_START,
    ST_VAL_WAIT,
    ST_ERR_MUL,
    ST_ERR_START,
    ST_ERR_WAIT,
    ST_EMIT
  } ssn_state_t;

endpackage

/* rtl/ssn_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on ssn_pkg for operand widths.
`timescale 1ns / 1ps

module ssn_mul (
  input  logic                              clk,
  input  logic signed [ssn_pkg::MA_W-1:0]   a,
  input  logic signed [ssn_pkg::MB_W-1:0]   b,
  output logic signed [ssn_pkg::PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* rtl/ssn_div.sv */
// Restoring divider, one quotient bit per cycle, with saturation to the
// signed result range. Depends on ssn_pkg.
`timescale 1ns / 1ps

module ssn_div (
  input  logic                           clk,
  input  logic                           rst,
  input  ssn_pkg::div_req_t              req,
  input  logic [ssn_pkg::NUM_W-1:0]      num,
  input  logic [ssn_pkg::DIFF_W-1:0]     den,
  output ssn_pkg::div_rsp_t              rsp
);

  localparam int VW = ssn_pkg::VALUE_WIDTH;
  localparam int DW = ssn_pkg::DIFF_W;

  localparam logic signed [VW-1:0] Q_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] Q_MIN = {1'b1, {(VW-1){1'b0}}};

  ssn_pkg::div_state_t state, state_next;

  logic [DW-1:0]                 rem;
  logic [DW-1:0]                 den_r;
  logic [VW-1:0]                 num_lo;
  logic [VW-1:0]                 q;
  logic [ssn_pkg::CNT_W-1:0]     cnt;
  logic                          neg_r;
  logic                          sat_r;
  logic signed [VW-1:0]          quot_r;

  logic [DW:0]   trial;
  logic [DW:0]   operand;
  logic [DW+1:0] diff;
  logic          ge;
  logic          last_step;

  // One compare-subtract serves the overflow check and every step.
  assign trial     = {rem, num_lo[VW-1]};
  assign operand   = (state == ssn_pkg::DIV_CHECK) ? {1'b0, rem} : trial;
  assign diff      = {1'b0, operand} - {2'b00, den_r};
  assign ge        = ~diff[DW+1];
  assign last_step = (cnt == ssn_pkg::CNT_W'(VW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssn_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ssn_pkg::DIV_IDLE: begin
        if (req.start) begin
          state_next = ssn_pkg::DIV_CHECK;
        end
      end
      ssn_pkg::DIV_CHECK: begin
        state_next = ge ? ssn_pkg::DIV_DONE : ssn_pkg::DIV_STEP;
      end
      ssn_pkg::DIV_STEP: begin
        if (last_step) begin
          state_next = ssn_pkg::DIV_DONE;
        end
      end
      ssn_pkg::DIV_DONE: begin
        state_next = ssn_pkg::DIV_IDLE;
      end
      default: begin
        state_next = ssn_pkg::DIV_IDLE;
      end
    endcase
  end

  logic [VW-1:0] q_fin;
  assign q_fin = {q[VW-2:0], ge};

  always_ff @(posedge clk) begin
    case (state)
      ssn_pkg::DIV_IDLE: begin
        if (req.start) begin
          // High part of the dividend: if it reaches the divisor, the
          // quotient needs more than VW bits.
          rem    <= DW'(num[ssn_pkg::NUM_W-1:VW]);
          num_lo <= num[VW-1:0];
          den_r  <= den;
          neg_r  <= req.neg;
        end
      end
      ssn_pkg::DIV_CHECK: begin
        cnt    <= '0;
        sat_r  <= ge;
        quot_r <= neg_r ? Q_MIN : Q_MAX;
      end
      ssn_pkg::DIV_STEP: begin
        rem    <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_lo <= num_lo << 1;
        q      <= q_fin;
        cnt    <= cnt + 1'b1;
        if (last_step) begin
          if (neg_r) begin
            if (q_fin[VW-1] && (|q_fin[VW-2:0])) begin
              sat_r  <= 1'b1;
              quot_r <= Q_MIN;
            end else begin
              sat_r  <= 1'b0;
              quot_r <= -signed'(q_fin);
            end
          end else if (q_fin[VW-1]) begin
            sat_r  <= 1'b1;
            quot_r <= Q_MAX;
          end else begin
            sat_r  <= 1'b0;
            quot_r <= signed'(q_fin);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.done = (state == ssn_pkg::DIV_DONE);
  assign rsp.sat  = sat_r;
  assign rsp.quot = quot_r;

endmodule

/* rtl/spherical_shell_normaliser_core.sv */
// Spherical shell normaliser: top level, sequencer and edge datapath.
// Depends on ssn_pkg, ssn_mul and ssn_div.
`timescale 1ns / 1ps
//
// Bins of a radial series enter on in_valid/in_stall/in_data, one at a
// time, the series ending at the bin with last_bin set. Each result leaves
// on out_valid/out_stall/out_data. errors_present is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce. The first bin of a series
// gives no result at once; the second bin gives two (first and second
// bin), every later bin one. A series of one bin returns it unchanged.
// Each shell runs through one shared multiplier (square, cube, value or
// error times 3/(2*pi)) and, unless its volume is zero, one restoring
// divider. With errors present, each divided shell also divides its error
// after its value; the second bin of a series also computes the first
// edge plus a second shell. in_stall is high from acceptance until the
// last result of the item is loaded into the output register (a held
// first bin gives none), so the next item is taken while that result
// still waits. While out_stall holds a result, the block waits with its
// next result and out_data does not change. rst (synchronous) empties the
// output register, drops any held bin and clears errors_present.

module spherical_shell_normaliser_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ssn_pkg::ssn_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ssn_pkg::ssn_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  localparam int XW   = ssn_pkg::X_WIDTH;
  localparam int VW   = ssn_pkg::VALUE_WIDTH;
  localparam int EW   = ssn_pkg::EDGE_W;
  localparam int XT   = ssn_pkg::EXT_W;
  localparam int DW   = ssn_pkg::DIFF_W;
  localparam int CW   = ssn_pkg::CUBE_W;
  localparam int MA_W = ssn_pkg::MA_W;
  localparam int MB_W = ssn_pkg::MB_W;

  function automatic logic signed [EW-1:0] sat_edge(input logic signed [XT-1:0] e);
    logic fits;
    fits = (&e[XT-1:EW-1]) || !(|e[XT-1:EW-1]);
    if (fits) begin
      sat_edge = e[EW-1:0];
    end else if (e[XT-1]) begin
      sat_edge = {1'b1, {XW{1'b0}}};
    end else begin
      sat_edge = {1'b0, {XW{1'b1}}};
    end
  endfunction

  ssn_pkg::ssn_state_t state, state_next;
  ssn_pkg::bins_t      bins_seen;

  logic                errors_present;
  ssn_pkg::ssn_in_t    in_r;
  logic signed [XW-1:0] held_centre;
  logic signed [VW-1:0] held_value;
  logic signed [VW-1:0] held_error;
  logic signed [EW-1:0] left_pos;
  logic signed [CW-1:0] left_cube;
  logic signed [EW-1:0] shell_edge;
  logic signed [DW-1:0] vol_diff;
  logic signed [VW-1:0] sh_value;
  logic signed [VW-1:0] sh_error;
  logic                 sh_last;
  logic                 first_pair;
  logic signed [VW-1:0] res_value;
  logic signed [VW-1:0] res_error;
  logic [1:0]           res_status;
  logic                 res_last;
  logic                 val_sat;

  logic signed [MA_W-1:0]            mul_a;
  logic signed [MB_W-1:0]            mul_b;
  logic signed [ssn_pkg::PROD_W-1:0] prod;
  logic signed [CW-1:0]              cube;
  ssn_pkg::div_req_t                 div_req;
  ssn_pkg::div_rsp_t                 div_rsp;
  logic [DW-1:0]                     div_den;
  logic                              out_load;

  logic [VW-1:0]        abs_value;
  logic [VW-1:0]        abs_error;
  logic signed [XT-1:0] first_left;
  logic signed [XT-1:0] first_right;
  logic signed [XT-1:0] next_right;

  assign cube      = prod[CW-1:0];
  assign abs_value = sh_value[VW-1] ? VW'(-sh_value) : VW'(sh_value);
  assign abs_error = sh_error[VW-1] ? VW'(-sh_error) : VW'(sh_error);
  assign div_den   = vol_diff[DW-1] ? DW'(-vol_diff) : DW'(vol_diff);

  // Edges in Q.11: left0 = 3*c0 - c1, right = 4*c - left.
  assign first_left  = (XT'(held_centre) <<< 1) + XT'(held_centre) - XT'(in_r.bin_centre);
  assign first_right = (XT'(held_centre) <<< 2) - XT'(shell_edge);
  assign next_right  = (XT'(in_r.bin_centre) <<< 2) - XT'(left_pos);

  ssn_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ssn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .num (prod[ssn_pkg::NUM_W-1:0]),
    .den (div_den),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = (state != ssn_pkg::ST_IDLE);
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    out_load    = 1'b0;
    case (state)
      ssn_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ssn_pkg::ST_START;
        end
      end
      ssn_pkg::ST_START: begin
        case (bins_seen)
          ssn_pkg::BINS_NONE:   state_next = in_r.last_bin ? ssn_pkg::ST_EMIT : ssn_pkg::ST_IDLE;
          ssn_pkg::BINS_HELD:   state_next = ssn_pkg::ST_LEFT_SQ;
          default:              state_next = ssn_pkg::ST_SH_SQ;
        endcase
      end
      ssn_pkg::ST_LEFT_SQ, ssn_pkg::ST_SH_SQ: begin
        mul_a      = MA_W'(shell_edge);
        mul_b      = MB_W'(shell_edge);
        state_next = (state == ssn_pkg::ST_LEFT_SQ) ? ssn_pkg::ST_LEFT_CUBE
                                                    : ssn_pkg::ST_SH_CUBE;
      end
      ssn_pkg::ST_LEFT_CUBE, ssn_pkg::ST_SH_CUBE: begin
        mul_a      = prod[MA_W-1:0];
        mul_b      = MB_W'(shell_edge);
        state_next = (state == ssn_pkg::ST_LEFT_CUBE) ? ssn_pkg::ST_LEFT_SET
                                                      : ssn_pkg::ST_SH_DIFF;
      end
      ssn_pkg::ST_LEFT_SET: begin
        state_next = ssn_pkg::ST_SH_SQ;
      end
      ssn_pkg::ST_SH_DIFF: begin
        state_next = ssn_pkg::ST_SH_CHECK;
      end
      ssn_pkg::ST_SH_CHECK: begin
        state_next = (vol_diff == '0) ? ssn_pkg::ST_EMIT : ssn_pkg::ST_VAL_MUL;
      end
      ssn_pkg::ST_VAL_MUL: begin
        mul_a      = MA_W'(abs_value);
        mul_b      = MB_W'(ssn_pkg::KINV_X2);
        state_next = ssn_pkg::ST_VAL_START;
      end
      ssn_pkg::ST_VAL_START: begin
        div_req.start = 1'b1;
        div_req.neg   = sh_value[VW-1] ^ vol_diff[DW-1];
        state_next    = ssn_pkg::ST_VAL_WAIT;
      end
      ssn_pkg::ST_VAL_WAIT: begin
        if (div_rsp.done) begin
          state_next = errors_present ? ssn_pkg::ST_ERR_MUL : ssn_pkg::ST_EMIT;
        end
      end
      ssn_pkg::ST_ERR_MUL: begin
        mul_a      = MA_W'(abs_error);
        mul_b      = MB_W'(ssn_pkg::KINV_X2);
        state_next = ssn_pkg::ST_ERR_START;
      end
      ssn_pkg::ST_ERR_START: begin
        div_req.start = 1'b1;
        div_req.neg   = sh_error[VW-1] ^ vol_diff[DW-1];
        state_next    = ssn_pkg::ST_ERR_WAIT;
      end
      ssn_pkg::ST_ERR_WAIT: begin
        if (div_rsp.done) begin
          state_next = ssn_pkg::ST_EMIT;
        end
      end
      ssn_pkg::ST_EMIT: begin
        out_load = !out_valid || !out_stall;
        if (out_load) begin
          state_next = first_pair ? ssn_pkg::ST_SH_SQ : ssn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ssn_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bins_seen      <= ssn_pkg::BINS_NONE;
      errors_present <= 1'b0;
      out_valid      <= 1'b0;
      first_pair     <= 1'b0;
    end else begin
      if (cfg_we) begin
        errors_present <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ssn_pkg::ST_START) begin
        case (bins_seen)
          ssn_pkg::BINS_NONE: begin
            if (!in_r.last_bin) begin
              bins_seen <= ssn_pkg::BINS_HELD;
            end
            first_pair <= 1'b0;
          end
          ssn_pkg::BINS_HELD: begin
            bins_seen  <= in_r.last_bin ? ssn_pkg::BINS_NONE : ssn_pkg::BINS_STREAM;
            first_pair <= 1'b1;
          end
          default: begin
            bins_seen  <= in_r.last_bin ? ssn_pkg::BINS_NONE : ssn_pkg::BINS_STREAM;
            first_pair <= 1'b0;
          end
        endcase
      end else if (out_load) begin
        first_pair <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.normalised_value <= res_value;
      out_data.normalised_error <= errors_present ? res_error : '0;
      out_data.result_status    <= res_status;
      out_data.last_result      <= res_last;
    end
    case (state)
      ssn_pkg::ST_IDLE: begin
        if (in_valid) begin
          in_r <= in_data;
        end
      end
      ssn_pkg::ST_START: begin
        case (bins_seen)
          ssn_pkg::BINS_NONE: begin
            held_centre <= in_r.bin_centre;
            held_value  <= in_r.sample_value;
            held_error  <= in_r.sample_error;
            // A series of one bin passes through unchanged.
            res_value   <= in_r.sample_value;
            res_error   <= in_r.sample_error;
            res_status  <= ssn_pkg::STATUS_OK;
            res_last    <= 1'b1;
          end
          ssn_pkg::BINS_HELD: begin
            shell_edge <= sat_edge(first_left);
          end
          default: begin
            shell_edge <= sat_edge(next_right);
            sh_value   <= in_r.sample_value;
            sh_error   <= in_r.sample_error;
            sh_last    <= in_r.last_bin;
          end
        endcase
      end
      ssn_pkg::ST_LEFT_SET: begin
        left_pos   <= shell_edge;
        left_cube  <= cube;
        shell_edge <= sat_edge(first_right);
        sh_value   <= held_value;
        sh_error   <= held_error;
        sh_last    <= 1'b0;
      end
      ssn_pkg::ST_SH_DIFF: begin
        vol_diff  <= DW'(cube) - DW'(left_cube);
        left_pos  <= shell_edge;
        left_cube <= cube;
      end
      ssn_pkg::ST_SH_CHECK: begin
        res_last <= sh_last;
        if (vol_diff == '0) begin
          res_value  <= sh_value;
          res_error  <= sh_error;
          res_status <= ssn_pkg::STATUS_ZERO_VOLUME;
        end
      end
      ssn_pkg::ST_VAL_WAIT: begin
        if (div_rsp.done) begin
          res_value <= div_rsp.quot;
          res_error <= '0;
          val_sat   <= div_rsp.sat;
          res_status <= div_rsp.sat ? ssn_pkg::STATUS_SATURATED : ssn_pkg::STATUS_OK;
        end
      end
      ssn_pkg::ST_ERR_WAIT: begin
        if (div_rsp.done) begin
          res_error  <= div_rsp.quot;
          res_status <= (val_sat || div_rsp.sat) ? ssn_pkg::STATUS_SATURATED
                                                 : ssn_pkg::STATUS_OK;
        end
      end
      ssn_pkg::ST_EMIT: begin
        // After the first shell of a pair, advance to the second bin.
        if (out_load && first_pair) begin
          shell_edge <= sat_edge(next_right);
          sh_value   <= in_r.sample_value;
          sh_error   <= in_r.sample_error;
          sh_last    <= in_r.last_bin;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/ssn_checker.sv */
// Port-level checks of the spherical shell normaliser, bound to the top.
// Depends on ssn_pkg and spherical_shell_normaliser_core_macros.svh.
`timescale 1ns / 1ps
`include "spherical_shell_normaliser_core_macros.svh"

module ssn_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ssn_pkg::ssn_out_t out_data
);

  // Coming out of reset: ready for an item, nothing to deliver.
  `SSN_ASSERT_ALWAYS(a_reset_idle, rst |=> !in_stall && !out_valid, "not idle after reset")

  // An accepted item keeps the block busy.
  `SSN_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "ready right after accept")

  // A result is only produced by work on an accepted item.
  `SSN_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result while idle")

  // A held result stays put.
  `SSN_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data),
              "stalled result changed")

  `SSN_ASSERT(a_status_code, out_valid |-> out_data.result_status != 2'd3, "unknown status")

endmodule

bind spherical_shell_normaliser_core ssn_checker u_ssn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
